@@ rtl/tag_presence_debouncer_core_assert.svh @@
// Assertion macros for the tag presence debouncer.
// Each macro expects clk and rst_n in scope.
`ifndef TAG_PRESENCE_DEBOUNCER_CORE_ASSERT_SVH
`define TAG_PRESENCE_DEBOUNCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define TPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tag presence debouncer: same-cycle check failed");

// Next-cycle implication.
`define TPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tag presence debouncer: next-cycle check failed");

`endif

@@ rtl/tpd_pkg.sv @@
package tpd_pkg;

    localparam int UID_LEN_BITS = 4;
    localparam int NOW_BITS     = 32;
    localparam int DEB_BITS     = 16;
    localparam int THR_BITS     = 8;
    localparam int MISS_BITS    = 8;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DAT_BITS = 16;

    // poll outcome codes (code 3 acts as link error)
    localparam logic [1:0] POLL_FOUND    = 2'd0;
    localparam logic [1:0] POLL_MISS     = 2'd1;
    localparam logic [1:0] POLL_LINK_ERR = 2'd2;

    // result event codes
    localparam logic [1:0] EVT_NONE     = 2'd0;
    localparam logic [1:0] EVT_DETECTED = 2'd1;
    localparam logic [1:0] EVT_REMOVED  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REMOVAL  = 8'd1;

    localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET = 16'd1000;
    localparam logic [THR_BITS-1:0]  REMOVAL_RESET  = 8'd3;
    localparam logic [MISS_BITS-1:0] MISS_MAX       = 8'hFF;

    typedef struct packed {
        logic                    same;    // identifier and length match stored
        logic [UID_LEN_BITS-1:0] len;     // length clipped to UID_MAX_BYTES
    } uid_match_t;

endpackage

@@ rtl/tag_presence_debouncer_core.sv @@
// Channel  Handshake               Payload
// -------  ----------------------  ----------------------------------------------
// in       in_valid / in_ready     poll_result, uid_low, uid_high, uid_nbytes, now_ms
// out      out_valid / out_ready   event_res, tag_present
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready is high; each beat passes through
// the input register and then the result register, and the state update
// (identifier compare, time subtract, miss counter) sits between them.
// cfg_ready is always high. Reset: rst_n, asynchronous, active low.
// A stalled out channel holds the result and backs up through in_ready.
module tag_presence_debouncer_core
    import tpd_pkg::*;
#(
    parameter int UID_MAX_BYTES = 10,
    parameter int TIME_BITS     = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              poll_result,
    input  logic [63:0]             uid_low,
    input  logic [15:0]             uid_high,
    input  logic [UID_LEN_BITS-1:0] uid_nbytes,
    input  logic [NOW_BITS-1:0]     now_ms,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              event_res,
    output logic                    tag_present,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_DAT_BITS-1:0] cfg_data
);

    // ---- configuration registers ----
    logic [DEB_BITS-1:0] debounce_reg;
    logic [THR_BITS-1:0] threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            threshold_reg <= REMOVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg  <= cfg_data;
                REG_REMOVAL:  threshold_reg <= cfg_data[THR_BITS-1:0];
                default:      ;   // unknown index ignored
            endcase
        end
    end

    // ---- input register ----
    logic                    hold_valid_reg;
    logic [1:0]              poll_reg;
    logic [63:0]             uid_low_reg;
    logic [15:0]             uid_high_reg;
    logic [UID_LEN_BITS-1:0] len_reg;
    logic [NOW_BITS-1:0]     now_reg;

    logic out_valid_reg;
    logic advance;

    // held beat moves into the result register when that register is free
    assign advance  = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (in_ready)
            hold_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            poll_reg     <= poll_result;
            uid_low_reg  <= uid_low;
            uid_high_reg <= uid_high;
            len_reg      <= uid_nbytes;
            now_reg      <= now_ms;
        end
    end

    // ---- tracked tag state ----
    logic [UID_MAX_BYTES-1:0][7:0] stored_uid_reg;
    logic [UID_LEN_BITS-1:0]       stored_len_reg;
    logic [TIME_BITS-1:0]          last_time_reg;
    logic                          present_reg;
    logic [MISS_BITS-1:0]          miss_reg;

    // candidate bytes: byte 0 in uid_low[7:0], byte 8 in uid_high[7:0]
    logic [79:0]                   uid_all;
    logic [UID_MAX_BYTES-1:0][7:0] cand;
    uid_match_t                    match;
    logic [UID_MAX_BYTES-1:0]      byte_en;

    assign uid_all = {uid_high_reg, uid_low_reg};

    for (genvar i = 0; i < UID_MAX_BYTES; i++) begin : g_cand
        assign cand[i] = uid_all[8*i +: 8];
    end

    tpd_uid_cmp #(
        .UID_MAX_BYTES (UID_MAX_BYTES)
    ) u_cmp (
        .cand       (cand),
        .stored     (stored_uid_reg),
        .uid_nbytes (len_reg),
        .stored_len (stored_len_reg),
        .match      (match),
        .byte_en    (byte_en)
    );

    // wrapping time difference in TIME_BITS
    logic [TIME_BITS-1:0] now_ext;
    logic [TIME_BITS-1:0] time_diff;
    logic                 expired;

    assign now_ext   = TIME_BITS'(now_reg);
    assign time_diff = now_ext - last_time_reg;
    assign expired   = time_diff > TIME_BITS'(debounce_reg);

    logic                          found;
    logic                          missed;
    logic                          report;
    logic                          removal;
    logic [MISS_BITS-1:0]          miss_inc;

    logic [UID_MAX_BYTES-1:0][7:0] stored_uid_next;
    logic [UID_LEN_BITS-1:0]       stored_len_next;
    logic [TIME_BITS-1:0]          last_time_next;
    logic                          present_next;
    logic [MISS_BITS-1:0]          miss_next;
    logic [1:0]                    event_next;

    assign found    = (poll_reg == POLL_FOUND);
    assign missed   = (poll_reg == POLL_MISS);
    assign miss_inc = (miss_reg == MISS_MAX) ? miss_reg : miss_reg + 1'b1;
    assign report   = found && (!match.same || expired || !present_reg);
    assign removal  = missed && present_reg && (miss_inc >= threshold_reg);

    always_comb
    begin
        stored_uid_next = stored_uid_reg;
        stored_len_next = stored_len_reg;
        last_time_next  = last_time_reg;
        present_next    = present_reg;
        miss_next       = miss_reg;
        event_next      = EVT_NONE;

        if (found)
        begin
            miss_next = '0;
            if (report)
            begin
                // only the bytes within the new length are copied
                for (int i = 0; i < UID_MAX_BYTES; i++)
                begin
                    if (byte_en[i])
                        stored_uid_next[i] = cand[i];
                end
                stored_len_next = match.len;
                last_time_next  = now_ext;
                present_next    = 1'b1;
                event_next      = EVT_DETECTED;
            end
        end
        else if (missed)
        begin
            miss_next = miss_inc;
            if (removal)
            begin
                present_next = 1'b0;
                event_next   = EVT_REMOVED;
            end
        end
        // link error: nothing changes
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_uid_reg <= '0;
            stored_len_reg <= '0;
            last_time_reg  <= '0;
            present_reg    <= 1'b0;
            miss_reg       <= '0;
        end
        else if (advance)
        begin
            stored_uid_reg <= stored_uid_next;
            stored_len_reg <= stored_len_next;
            last_time_reg  <= last_time_next;
            present_reg    <= present_next;
            miss_reg       <= miss_next;
        end
    end

    // ---- result register ----
    logic [1:0] event_reg;
    logic       tag_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= hold_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg       <= event_next;
            tag_present_reg <= present_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign tag_present = tag_present_reg;

endmodule

@@ rtl/tpd_uid_cmp.sv @@
module tpd_uid_cmp
    import tpd_pkg::*;
#(
    parameter int UID_MAX_BYTES = 10
)
(
    input  logic [UID_MAX_BYTES-1:0][7:0] cand,
    input  logic [UID_MAX_BYTES-1:0][7:0] stored,
    input  logic [UID_LEN_BITS-1:0]       uid_nbytes,
    input  logic [UID_LEN_BITS-1:0]       stored_len,
    output uid_match_t                    match,
    output logic [UID_MAX_BYTES-1:0]      byte_en
);

    localparam logic [UID_LEN_BITS-1:0] MAX_LEN = UID_LEN_BITS'(UID_MAX_BYTES);

    logic [UID_LEN_BITS-1:0]  len_sat;
    logic [UID_MAX_BYTES-1:0] byte_ok;

    assign len_sat = (uid_nbytes > MAX_LEN) ? MAX_LEN : uid_nbytes;

    for (genvar i = 0; i < UID_MAX_BYTES; i++) begin : g_byte
        assign byte_en[i] = UID_LEN_BITS'(i) < len_sat;
        assign byte_ok[i] = !byte_en[i] || (cand[i] == stored[i]);
    end

    assign match.len  = len_sat;
    assign match.same = (len_sat == stored_len) && (&byte_ok);

endmodule

@@ rtl/tpd_checker.sv @@
`include "tag_presence_debouncer_core_assert.svh"

module tpd_checker
    import tpd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] event_res,
    input logic       tag_present
);

    // a stalled result stays offered and unchanged
    `TPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `TPD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(event_res) && $stable(tag_present))

    // a detection leaves the tag present, a removal leaves it absent
    `TPD_ASSERT_NOW(a_detect_present, out_valid && event_res == EVT_DETECTED, tag_present)
    `TPD_ASSERT_NOW(a_remove_absent, out_valid && event_res == EVT_REMOVED, !tag_present)

endmodule

bind tag_presence_debouncer_core tpd_checker u_tpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .tag_present (tag_present)
);
